// ===== rtl/fss_pkg.sv =====
// shared types, codes and helpers for the fasta stream splitter
package fss_pkg;

    // output channel codes
    localparam logic [1:0] CH_NAME  = 2'd0;
    localparam logic [1:0] CH_ANNOT = 2'd1;
    localparam logic [1:0] CH_SEQ   = 2'd2;
    localparam logic [1:0] CH_ERR   = 2'd3;

    // error codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_SEQ_FIRST = 2'd1;
    localparam logic [1:0] ERR_TWO_HDR   = 2'd2;

    // file phase codes
    localparam logic [1:0] PH_TOP = 2'd0;
    localparam logic [1:0] PH_HDR = 2'd1;
    localparam logic [1:0] PH_SEQ = 2'd2;

    // name phase codes
    localparam logic [1:0] NP_SKIP = 2'd0;
    localparam logic [1:0] NP_TAKE = 2'd1;
    localparam logic [1:0] NP_DONE = 2'd2;

    // characters
    localparam logic [7:0] CHR_GT    = 8'h3E;
    localparam logic [7:0] CHR_COLON = 8'h3A;
    localparam logic [7:0] CHR_COMMA = 8'h2C;
    localparam logic [7:0] CHR_NL    = 8'h0A;
    localparam logic [7:0] CHR_FF    = 8'h0C;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_TAB   = 8'h09;
    localparam logic [7:0] CHR_CR    = 8'h0D;

    localparam logic [5:0] NAME_LIMIT_RESET = 6'd10;
    localparam int         MAX_RESULTS      = 3;

    typedef struct packed {
        logic [1:0] channel;
        logic [7:0] out_byte;
        logic [1:0] error_code;
        logic       last_result;
    } t_result;

    // all results caused by one input item
    typedef struct packed {
        t_result [MAX_RESULTS-1:0] res;
        logic [1:0]                count;
    } t_bundle;

    function automatic logic is_blank(input logic [7:0] b);
        is_blank = (b == CHR_SPACE) || ((b >= CHR_TAB) && (b <= CHR_CR));
    endfunction

    function automatic t_result make_result(input logic [1:0] ch, input logic [7:0] b,
                                            input logic [1:0] err);
        t_result r;
        r.channel     = ch;
        r.out_byte    = b;
        r.error_code  = err;
        r.last_result = 1'b0;
        make_result   = r;
    endfunction

endpackage

// ===== rtl/fss_in_if.sv =====
// input byte channel of the fasta stream splitter
interface fss_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_marker;

    modport source (output valid, output data_byte, output end_marker, input ready);
    modport sink (input valid, input data_byte, input end_marker, output ready);
endinterface

// ===== rtl/fss_out_if.sv =====
// result channel of the fasta stream splitter
interface fss_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] channel;
    logic [7:0] out_byte;
    logic [1:0] error_code;
    logic       last_result;

    modport source (output valid, output channel, output out_byte, output error_code,
                    output last_result, input ready);
    modport sink (input valid, input channel, input out_byte, input error_code,
                  input last_result, output ready);
endinterface

// ===== rtl/fss_core.sv =====
// parser state and per-byte classification, builds the results of one item
module fss_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [5:0]       i_cfg_data,
    input  logic             i_accept,
    input  logic [7:0]       i_data_byte,
    input  logic             i_end_marker,
    output fss_pkg::t_bundle o_bundle
);

    logic [5:0] r_name_limit;
    logic [1:0] r_file_phase, n_file_phase;
    logic       r_at_line_start, n_at_line_start;
    logic       r_line_is_header, n_line_is_header;
    logic [1:0] r_name_phase, n_name_phase;
    logic [5:0] r_name_count, n_name_count;
    logic       r_sequence_open, n_sequence_open;
    logic       r_halted, n_halted;

    fss_pkg::t_bundle w_bundle;

    always_comb begin
        logic [1:0] cnt;
        logic [1:0] np;
        logic [7:0] b;
        n_file_phase     = r_file_phase;
        n_at_line_start  = r_at_line_start;
        n_line_is_header = r_line_is_header;
        n_name_phase     = r_name_phase;
        n_name_count     = r_name_count;
        n_sequence_open  = r_sequence_open;
        n_halted         = r_halted;
        w_bundle         = '0;
        cnt              = 2'd0;
        np               = r_name_phase;
        b                = i_data_byte;
        if (!r_halted) begin
            if (i_end_marker) begin
                if (!r_at_line_start && r_line_is_header) begin
                    w_bundle.res[0] = fss_pkg::make_result(fss_pkg::CH_NAME,
                                                           fss_pkg::CHR_NL, fss_pkg::ERR_NONE);
                    w_bundle.res[1] = fss_pkg::make_result(fss_pkg::CH_ANNOT,
                                                           fss_pkg::CHR_NL, fss_pkg::ERR_NONE);
                    w_bundle.res[2] = fss_pkg::make_result(fss_pkg::CH_ANNOT,
                                                           fss_pkg::CHR_FF, fss_pkg::ERR_NONE);
                    cnt = 2'd3;
                end else if (r_sequence_open) begin
                    // a header line in progress cannot coexist with an open sequence
                    w_bundle.res[0] = fss_pkg::make_result(fss_pkg::CH_SEQ,
                                                           fss_pkg::CHR_NL, fss_pkg::ERR_NONE);
                    cnt = 2'd1;
                end
                n_file_phase     = fss_pkg::PH_TOP;
                n_at_line_start  = 1'b1;
                n_line_is_header = 1'b0;
                n_name_phase     = fss_pkg::NP_SKIP;
                n_name_count     = 6'd0;
                n_sequence_open  = 1'b0;
            end else if (r_at_line_start) begin
                if (b == fss_pkg::CHR_GT) begin
                    if (r_file_phase == fss_pkg::PH_HDR) begin
                        w_bundle.res[0] = fss_pkg::make_result(fss_pkg::CH_ERR, 8'd0,
                                                               fss_pkg::ERR_TWO_HDR);
                        cnt      = 2'd1;
                        n_halted = 1'b1;
                    end else begin
                        n_file_phase = fss_pkg::PH_HDR;
                        if (r_sequence_open) begin
                            w_bundle.res[0] = fss_pkg::make_result(fss_pkg::CH_SEQ,
                                                    fss_pkg::CHR_NL, fss_pkg::ERR_NONE);
                            w_bundle.res[1] = fss_pkg::make_result(fss_pkg::CH_ANNOT, b,
                                                                   fss_pkg::ERR_NONE);
                            cnt = 2'd2;
                        end else begin
                            w_bundle.res[0] = fss_pkg::make_result(fss_pkg::CH_ANNOT, b,
                                                                   fss_pkg::ERR_NONE);
                            cnt = 2'd1;
                        end
                        n_sequence_open  = 1'b0;
                        n_line_is_header = 1'b1;
                        n_name_phase     = fss_pkg::NP_SKIP;
                        n_name_count     = 6'd0;
                        n_at_line_start  = 1'b0;
                    end
                end else if (r_file_phase == fss_pkg::PH_TOP) begin
                    w_bundle.res[0] = fss_pkg::make_result(fss_pkg::CH_ERR, 8'd0,
                                                           fss_pkg::ERR_SEQ_FIRST);
                    cnt      = 2'd1;
                    n_halted = 1'b1;
                end else begin
                    n_file_phase     = fss_pkg::PH_SEQ;
                    n_sequence_open  = 1'b1;
                    n_line_is_header = 1'b0;
                    if (b != fss_pkg::CHR_NL) begin
                        n_at_line_start = 1'b0;
                        if (!fss_pkg::is_blank(b)) begin
                            w_bundle.res[0] = fss_pkg::make_result(fss_pkg::CH_SEQ, b,
                                                                   fss_pkg::ERR_NONE);
                            cnt = 2'd1;
                        end
                    end
                end
            end else if (r_line_is_header) begin
                if (b == fss_pkg::CHR_NL) begin
                    w_bundle.res[0] = fss_pkg::make_result(fss_pkg::CH_NAME,
                                                           fss_pkg::CHR_NL, fss_pkg::ERR_NONE);
                    w_bundle.res[1] = fss_pkg::make_result(fss_pkg::CH_ANNOT,
                                                           fss_pkg::CHR_NL, fss_pkg::ERR_NONE);
                    w_bundle.res[2] = fss_pkg::make_result(fss_pkg::CH_ANNOT,
                                                           fss_pkg::CHR_FF, fss_pkg::ERR_NONE);
                    cnt              = 2'd3;
                    n_at_line_start  = 1'b1;
                    n_line_is_header = 1'b0;
                end else begin
                    w_bundle.res[0] = fss_pkg::make_result(fss_pkg::CH_ANNOT, b,
                                                           fss_pkg::ERR_NONE);
                    cnt = 2'd1;
                    if (np == fss_pkg::NP_SKIP && !fss_pkg::is_blank(b)) begin
                        np = fss_pkg::NP_TAKE;
                    end
                    if (np == fss_pkg::NP_TAKE) begin
                        if ((r_name_count < r_name_limit) && !fss_pkg::is_blank(b)
                            && (b != fss_pkg::CHR_COLON) && (b != fss_pkg::CHR_COMMA)) begin
                            w_bundle.res[1] = fss_pkg::make_result(fss_pkg::CH_NAME, b,
                                                                   fss_pkg::ERR_NONE);
                            cnt          = 2'd2;
                            n_name_count = r_name_count + 6'd1;
                        end else begin
                            np = fss_pkg::NP_DONE;
                        end
                    end
                    n_name_phase = np;
                end
            end else begin
                if (b == fss_pkg::CHR_NL) begin
                    n_at_line_start = 1'b1;
                end else if (!fss_pkg::is_blank(b)) begin
                    w_bundle.res[0] = fss_pkg::make_result(fss_pkg::CH_SEQ, b,
                                                           fss_pkg::ERR_NONE);
                    cnt = 2'd1;
                end
            end
        end
        w_bundle.count = cnt;
        for (int k = 0; k < fss_pkg::MAX_RESULTS; k++) begin
            w_bundle.res[k].last_result = (cnt != 2'd0) && (2'(k) == cnt - 2'd1);
        end
    end

    assign o_bundle = w_bundle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_name_limit     <= fss_pkg::NAME_LIMIT_RESET;
            r_file_phase     <= fss_pkg::PH_TOP;
            r_at_line_start  <= 1'b1;
            r_line_is_header <= 1'b0;
            r_name_phase     <= fss_pkg::NP_SKIP;
            r_name_count     <= 6'd0;
            r_sequence_open  <= 1'b0;
            r_halted         <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_name_limit <= i_cfg_data;
            end
            if (i_accept) begin
                r_file_phase     <= n_file_phase;
                r_at_line_start  <= n_at_line_start;
                r_line_is_header <= n_line_is_header;
                r_name_phase     <= n_name_phase;
                r_name_count     <= n_name_count;
                r_sequence_open  <= n_sequence_open;
                r_halted         <= n_halted;
            end
        end
    end

    // once halted, only reset brings the parser back
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("halt flag dropped without reset");

    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |-> (w_bundle.count == 2'd0))
        else $error("results produced while halted");

    a_err_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_bundle.count != 2'd0 && w_bundle.res[0].channel == fss_pkg::CH_ERR)
        |-> (w_bundle.count == 2'd1 && n_halted))
        else $error("error report not alone or did not halt");

    // the name counter never runs past the configured limit within a header
    a_name_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && n_name_count != r_name_count && n_name_count != 6'd0)
        |-> (r_name_count < r_name_limit))
        else $error("name counter stepped past limit");

endmodule

// ===== rtl/fss_out.sv =====
// result buffer that drains the results of one item, one transaction per cycle while the sink is ready
module fss_out (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  fss_pkg::t_bundle i_bundle,
    output logic             o_load_ready,
    fss_out_if.source        o_out
);

    fss_pkg::t_bundle r_buf;
    logic [1:0]       r_idx;
    logic [1:0]       r_cnt;
    logic             w_take;
    fss_pkg::t_result w_cur;

    assign w_cur        = r_buf.res[r_idx];
    assign w_take       = o_out.valid && o_out.ready;
    assign o_load_ready = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && o_out.ready);

    assign o_out.valid       = (r_cnt != 2'd0);
    assign o_out.channel     = w_cur.channel;
    assign o_out.out_byte    = w_cur.out_byte;
    assign o_out.error_code  = w_cur.error_code;
    assign o_out.last_result = w_cur.last_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
            r_cnt <= 2'd0;
        end else if (i_load && i_bundle.count != 2'd0) begin
            r_idx <= 2'd0;
            r_cnt <= i_bundle.count;
        end else if (w_take) begin
            r_idx <= r_idx + 2'd1;
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_bundle.count != 2'd0) begin
            r_buf <= i_bundle;
        end
    end

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != 2'd0) |-> (({1'b0, r_idx} + {1'b0, r_cnt}) <= 3'd3))
        else $error("result index out of range");

    a_last_marks_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.last_result == (r_cnt == 2'd1)))
        else $error("last_result does not match remaining count");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> (o_out.valid && $stable(r_idx)))
        else $error("pending result lost while stalled");

endmodule

// ===== rtl/fasta_stream_splitter.sv =====
// top level of the fasta stream splitter: parser core and result buffer
// the first result of an item is registered in the result buffer and offered in the cycle after its transaction
// throughput: one item per cycle while each item yields at most one result and the sink is ready;
//   an item with k results holds off the next item until its last result leaves through the single result port
// items that yield no result never stall the input unless the buffer is still draining
// reset (synchronous, active low) clears parser state and halt, name_limit returns to 10
module fasta_stream_splitter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [5:0] i_cfg_data,
    fss_in_if.sink     i_in,
    fss_out_if.source  o_out
);

    fss_pkg::t_bundle w_bundle;
    logic             w_load_ready;
    logic             w_accept;

    assign i_in.ready = w_load_ready;
    assign w_accept   = i_in.valid && w_load_ready;

    fss_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_accept     (w_accept),
        .i_data_byte  (i_in.data_byte),
        .i_end_marker (i_in.end_marker),
        .o_bundle     (w_bundle)
    );

    fss_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (w_accept),
        .i_bundle     (w_bundle),
        .o_load_ready (w_load_ready),
        .o_out        (o_out)
    );

endmodule

// ===== verif/fasta_stream_splitter_tb.sv =====
// self-checking testbench for the fasta stream splitter: directed and random text, scoreboard
module fasta_stream_splitter_tb;

    localparam logic [7:0] CHR_VT       = 8'h0B;
    localparam int         LONG_HOLD    = 200;
    localparam int         PHASE_ITEMS  = 72;
    localparam int         SETTLE       = 4;

    // scoreboard: tracks parser state and queues the bytes each transaction should produce
    class fasta_split_scoreboard;
        fss_pkg::t_result results_due[$];
        logic [5:0]       name_limit;
        logic [1:0]       file_phase;
        logic [1:0]       name_phase;
        logic [5:0]       name_count;
        bit               at_line_start;
        bit               line_is_header;
        bit               sequence_open;
        bit               halted;
        fss_pkg::t_result burst[fss_pkg::MAX_RESULTS];
        int               burst_len;
        int               n_fail;
        int               n_checked;
        int               n_headers;
        int               n_ends;

        function new();
            name_limit = fss_pkg::NAME_LIMIT_RESET;
            clear_stream();
            halted    = 1'b0;
            n_fail    = 0;
            n_checked = 0;
            n_headers = 0;
            n_ends    = 0;
        endfunction

        function void clear_stream();
            file_phase     = fss_pkg::PH_TOP;
            at_line_start  = 1'b1;
            line_is_header = 1'b0;
            name_phase     = fss_pkg::NP_SKIP;
            name_count     = '0;
            sequence_open  = 1'b0;
        endfunction

        function bit blank_byte(logic [7:0] b);
            return (b == fss_pkg::CHR_SPACE) ||
                   ((b >= fss_pkg::CHR_TAB) && (b <= fss_pkg::CHR_CR));
        endfunction

        function void add(logic [1:0] ch, logic [7:0] b, logic [1:0] err);
            burst[burst_len] = '{channel: ch, out_byte: b, error_code: err, last_result: 1'b0};
            burst_len++;
        endfunction

        function void predict_split(logic [7:0] b, logic e);
            burst_len = 0;
            if (halted) return;
            if (e) begin
                n_ends++;
                if (!at_line_start && line_is_header) begin
                    add(fss_pkg::CH_NAME, fss_pkg::CHR_NL, fss_pkg::ERR_NONE);
                    add(fss_pkg::CH_ANNOT, fss_pkg::CHR_NL, fss_pkg::ERR_NONE);
                    add(fss_pkg::CH_ANNOT, fss_pkg::CHR_FF, fss_pkg::ERR_NONE);
                end
                if (sequence_open) add(fss_pkg::CH_SEQ, fss_pkg::CHR_NL, fss_pkg::ERR_NONE);
                clear_stream();
            end else if (at_line_start) begin
                if (b == fss_pkg::CHR_GT) begin
                    if (file_phase == fss_pkg::PH_HDR) begin
                        add(fss_pkg::CH_ERR, 8'h00, fss_pkg::ERR_TWO_HDR);
                        halted = 1'b1;
                    end else begin
                        n_headers++;
                        file_phase = fss_pkg::PH_HDR;
                        if (sequence_open) begin
                            add(fss_pkg::CH_SEQ, fss_pkg::CHR_NL, fss_pkg::ERR_NONE);
                            sequence_open = 1'b0;
                        end
                        add(fss_pkg::CH_ANNOT, b, fss_pkg::ERR_NONE);
                        line_is_header = 1'b1;
                        name_phase     = fss_pkg::NP_SKIP;
                        name_count     = '0;
                        at_line_start  = 1'b0;
                    end
                end else if (file_phase == fss_pkg::PH_TOP) begin
                    add(fss_pkg::CH_ERR, 8'h00, fss_pkg::ERR_SEQ_FIRST);
                    halted = 1'b1;
                end else begin
                    // sequence line, an empty one still opens the sequence
                    file_phase     = fss_pkg::PH_SEQ;
                    sequence_open  = 1'b1;
                    line_is_header = 1'b0;
                    if (b != fss_pkg::CHR_NL) begin
                        at_line_start = 1'b0;
                        if (!blank_byte(b)) add(fss_pkg::CH_SEQ, b, fss_pkg::ERR_NONE);
                    end
                end
            end else if (line_is_header) begin
                if (b == fss_pkg::CHR_NL) begin
                    add(fss_pkg::CH_NAME, fss_pkg::CHR_NL, fss_pkg::ERR_NONE);
                    add(fss_pkg::CH_ANNOT, fss_pkg::CHR_NL, fss_pkg::ERR_NONE);
                    add(fss_pkg::CH_ANNOT, fss_pkg::CHR_FF, fss_pkg::ERR_NONE);
                    at_line_start  = 1'b1;
                    line_is_header = 1'b0;
                end else begin
                    add(fss_pkg::CH_ANNOT, b, fss_pkg::ERR_NONE);
                    if (name_phase == fss_pkg::NP_SKIP && !blank_byte(b))
                        name_phase = fss_pkg::NP_TAKE;
                    if (name_phase == fss_pkg::NP_TAKE) begin
                        if (name_count < name_limit && !blank_byte(b)
                            && b != fss_pkg::CHR_COLON && b != fss_pkg::CHR_COMMA) begin
                            add(fss_pkg::CH_NAME, b, fss_pkg::ERR_NONE);
                            name_count = name_count + 6'd1;
                        end else begin
                            name_phase = fss_pkg::NP_DONE;
                        end
                    end
                end
            end else begin
                if (b == fss_pkg::CHR_NL) at_line_start = 1'b1;
                else if (!blank_byte(b)) add(fss_pkg::CH_SEQ, b, fss_pkg::ERR_NONE);
            end
            if (burst_len > 0) burst[burst_len-1].last_result = 1'b1;
            for (int i = 0; i < burst_len; i++) results_due.push_back(burst[i]);
        endfunction

        task report_mismatch(string what);
            n_fail++;
            if (n_fail <= 30) $display("mismatch: %s", what);
        endtask

        task check_split_result(fss_pkg::t_result got);
            fss_pkg::t_result want;
            n_checked++;
            if (results_due.size() == 0) begin
                report_mismatch($sformatf("result %0d unexpected: ch %0d byte %02h err %0d",
                                          n_checked, got.channel, got.out_byte,
                                          got.error_code));
                return;
            end
            want = results_due.pop_front();
            if (got.channel !== want.channel)
                report_mismatch($sformatf("result %0d channel %0d, want %0d",
                                          n_checked, got.channel, want.channel));
            if (got.out_byte !== want.out_byte)
                report_mismatch($sformatf("result %0d byte %02h, want %02h",
                                          n_checked, got.out_byte, want.out_byte));
            if (got.error_code !== want.error_code)
                report_mismatch($sformatf("result %0d error %0d, want %0d",
                                          n_checked, got.error_code, want.error_code));
            if (got.last_result !== want.last_result)
                report_mismatch($sformatf("result %0d last %0d, want %0d",
                                          n_checked, got.last_result, want.last_result));
        endtask
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [5:0] i_cfg_data;

    fss_in_if  in_if ();
    fss_out_if out_if ();

    fasta_stream_splitter DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    fasta_split_scoreboard sb = new();

    bit    src_calm;
    bit    sink_calm;
    bit    hold_request;
    int    n_items;
    int    n_limits;
    int    n_long_holds;
    string error_case;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    initial begin
        #5000000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result sink: random stalls, calm stretches, one long hold on request
    initial begin
        int stall_left;
        int cyc;
        stall_left   = 0;
        cyc          = 0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            cyc++;
            if (cyc % 64 == 0) sink_calm = ($urandom_range(0, 3) == 0);
            if (hold_request) begin
                hold_request = 1'b0;
                out_if.ready = 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                n_long_holds++;
            end else if (stall_left > 0) begin
                out_if.ready = 1'b0;
                stall_left--;
            end else begin
                out_if.ready = 1'b1;
                stall_left   = pick_gap(sink_calm);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready)
            sb.check_split_result('{channel: out_if.channel, out_byte: out_if.out_byte,
                                    error_code: out_if.error_code,
                                    last_result: out_if.last_result});
    end

    task automatic send_item(logic [7:0] b, logic e);
        int gap;
        gap = pick_gap(src_calm);
        @(negedge i_clk);
        if (gap > 0) begin
            in_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid      = 1'b1;
        in_if.data_byte  = b;
        in_if.end_marker = e;
        do @(posedge i_clk); while (!(in_if.valid && in_if.ready));
        sb.predict_split(b, e);
    endtask

    task automatic release_input();
        @(negedge i_clk);
        in_if.valid = 1'b0;
    endtask

    // keep the stream legal so the block does not halt before the final error case
    task automatic put_byte(logic [7:0] b, logic e);
        logic [7:0] v;
        v = b;
        if (!e && sb.at_line_start) begin
            if (sb.file_phase == fss_pkg::PH_TOP && v != fss_pkg::CHR_GT) v = fss_pkg::CHR_GT;
            else if (sb.file_phase == fss_pkg::PH_HDR && v == fss_pkg::CHR_GT) v = "N";
        end
        send_item(v, e);
        n_items++;
    endtask

    task automatic wait_drain();
        while (sb.results_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_name_limit(logic [5:0] v);
        release_input();
        wait_drain();
        repeat (SETTLE) @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_data = v;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        sb.name_limit = v;
        n_limits++;
    endtask

    function automatic logic [7:0] rand_blank();
        case ($urandom_range(0, 4))
            0: return fss_pkg::CHR_SPACE;
            1: return fss_pkg::CHR_TAB;
            2: return fss_pkg::CHR_CR;
            3: return CHR_VT;
            default: return fss_pkg::CHR_FF;
        endcase
    endfunction

    function automatic logic [7:0] rand_name_byte();
        logic [7:0] b;
        if ($urandom_range(0, 9) == 0) return 8'($urandom_range(128, 255));
        do b = 8'($urandom_range(8'h21, 8'h7E));
        while (b == fss_pkg::CHR_COLON || b == fss_pkg::CHR_COMMA);
        return b;
    endfunction

    function automatic logic [7:0] rand_text_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == fss_pkg::CHR_NL);
        return b;
    endfunction

    function automatic logic [7:0] rand_seq_byte();
        string bases;
        int    r;
        bases = "ACGTNacgtn-*";
        r = $urandom_range(0, 99);
        if (r < 80) return bases[$urandom_range(0, bases.len() - 1)];
        if (r < 90) return rand_blank();
        return rand_text_byte();
    endfunction

    task automatic header_line();
        int name_len;
        int r;
        put_byte(fss_pkg::CHR_GT, 1'b0);
        repeat ($urandom_range(0, 2)) put_byte(rand_blank(), 1'b0);
        name_len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 70) : $urandom_range(0, 12);
        repeat (name_len) put_byte(rand_name_byte(), 1'b0);
        r = $urandom_range(0, 3);
        if (r == 1) put_byte(fss_pkg::CHR_SPACE, 1'b0);
        else if (r == 2) put_byte(fss_pkg::CHR_COLON, 1'b0);
        else if (r == 3) put_byte(fss_pkg::CHR_COMMA, 1'b0);
        repeat ($urandom_range(0, 8)) put_byte(rand_text_byte(), 1'b0);
        // now and then the stream ends inside the header line
        if ($urandom_range(0, 15) == 0) put_byte(8'($urandom), 1'b1);
        else put_byte(fss_pkg::CHR_NL, 1'b0);
    endtask

    task automatic sequence_lines();
        repeat ($urandom_range(0, 3)) begin
            if ($urandom_range(0, 7) != 0)
                repeat ($urandom_range(1, 20)) put_byte(rand_seq_byte(), 1'b0);
            put_byte(fss_pkg::CHR_NL, 1'b0);
        end
    endtask

    task automatic random_phase(int count);
        int start;
        start = n_items;
        while (n_items - start < count) begin
            src_calm = ($urandom_range(0, 3) == 0);
            header_line();
            sequence_lines();
            if ($urandom_range(0, 11) == 0)
                repeat ($urandom_range(1, 4))
                    put_byte(8'($urandom), ($urandom_range(0, 4) == 0));
            if ($urandom_range(0, 14) == 0) put_byte(8'($urandom), 1'b1);
        end
    endtask

    // drive the block into one of its halting errors, then show it stays silent
    task automatic halting_error();
        put_byte(8'h00, 1'b1);
        if ($urandom_range(0, 1) == 0) begin
            error_case = "sequence line before any header";
            send_item(($urandom_range(0, 1) == 0) ? fss_pkg::CHR_NL : 8'("A"), 1'b0);
        end else begin
            error_case = "two headers in a row";
            put_byte(fss_pkg::CHR_GT, 1'b0);
            put_byte("e", 1'b0);
            put_byte(fss_pkg::CHR_NL, 1'b0);
            send_item(fss_pkg::CHR_GT, 1'b0);
        end
        n_items++;
        repeat (4) send_item(8'($urandom), ($urandom_range(0, 2) == 0));
    endtask

    initial begin
        int guard;
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_data       = '0;
        in_if.valid      = 1'b0;
        in_if.data_byte  = '0;
        in_if.end_marker = 1'b0;
        src_calm         = 1'b0;
        sink_calm        = 1'b0;
        hold_request     = 1'b0;
        n_items          = 0;
        n_limits         = 1;
        n_long_holds     = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed, default name limit
        put_byte(8'h00, 1'b1);
        put_byte(fss_pkg::CHR_GT, 1'b0);
        put_byte(fss_pkg::CHR_SPACE, 1'b0);
        put_byte(8'hFF, 1'b0);
        put_byte("q", 1'b0);
        put_byte(fss_pkg::CHR_COMMA, 1'b0);
        put_byte("z", 1'b0);
        put_byte(fss_pkg::CHR_NL, 1'b0);
        put_byte("A", 1'b0);
        put_byte(fss_pkg::CHR_TAB, 1'b0);
        put_byte(8'h80, 1'b0);
        put_byte(fss_pkg::CHR_NL, 1'b0);
        put_byte(fss_pkg::CHR_NL, 1'b0);
        put_byte(fss_pkg::CHR_GT, 1'b0);
        put_byte(fss_pkg::CHR_NL, 1'b0);
        put_byte("C", 1'b0);
        put_byte(8'hFF, 1'b1);
        put_byte(fss_pkg::CHR_GT, 1'b0);
        put_byte("k", 1'b0);
        put_byte(fss_pkg::CHR_COLON, 1'b0);
        put_byte(8'h00, 1'b1);

        // a name limit of one cuts the name after one byte
        write_name_limit(6'd1);
        put_byte(fss_pkg::CHR_GT, 1'b0);
        put_byte("a", 1'b0);
        put_byte("b", 1'b0);
        put_byte(fss_pkg::CHR_NL, 1'b0);
        put_byte("G", 1'b0);
        put_byte(fss_pkg::CHR_NL, 1'b0);

        write_name_limit(6'd63);
        random_phase(PHASE_ITEMS);

        write_name_limit(6'($urandom_range(1, 63)));
        hold_request = 1'b1;
        random_phase(PHASE_ITEMS);

        write_name_limit(6'($urandom_range(1, 12)));
        random_phase(PHASE_ITEMS / 2);
        // sender waits for the block to empty completely
        release_input();
        wait_drain();
        random_phase(PHASE_ITEMS / 2);

        write_name_limit(6'd1);
        random_phase(PHASE_ITEMS);

        halting_error();
        release_input();

        guard = 0;
        while (sb.results_due.size() != 0 && guard < 50000) begin
            @(posedge i_clk);
            guard++;
        end
        if (sb.results_due.size() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.results_due.size()));
        repeat (10) @(posedge i_clk);

        $display("run: %0d text items, %0d headers, %0d end markers, %0d results, %0d limits",
                 n_items, sb.n_headers, sb.n_ends, sb.n_checked, n_limits);
        $display("run: %0d long output holds, closing error case: %s", n_long_holds, error_case);
        if (sb.n_fail == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/fss_pkg.sv
rtl/fss_in_if.sv
rtl/fss_out_if.sv
rtl/fss_core.sv
rtl/fss_out.sv
rtl/fasta_stream_splitter.sv
verif/fasta_stream_splitter_tb.sv
